[sv/sfir_pkg.sv]
// Shared widths, command codes and control types of the stereo FIR filter.
package sfir_pkg;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned COEF_W = 18;
  localparam int unsigned PROD_W = SMP_W + COEF_W;
  localparam int unsigned FRAC_W = 16;

  localparam logic signed [COEF_W-1:0] COEF_UNITY = 18'sd65536;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_WR_LEFT  = 2'd1,
    CMD_WR_RIGHT = 2'd2
  } cmd_e;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

[sv/sfir_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sfir_mac.sv]
// Multiply-accumulate unit of one channel with rounding and saturation of the sum.
module sfir_mac import sfir_pkg::*; #(
  parameter int unsigned ACC_W = 42
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic signed [SMP_W-1:0]  smp_i,
  output logic                     busy_o,
  output logic signed [SMP_W-1:0]  res_o
);

  localparam logic signed [ACC_W:0] RND_HALF =
    {{(ACC_W - FRAC_W + 1){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
  localparam logic signed [ACC_W-FRAC_W:0] SAT_MAX = (ACC_W - FRAC_W + 1)'(32767);
  localparam logic signed [ACC_W-FRAC_W:0] SAT_MIN = (ACC_W - FRAC_W + 1)'(-32768);

  logic signed [PROD_W-1:0]       prod_q;
  logic                           pv_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [ACC_W:0]          rnd;
  logic signed [ACC_W-FRAC_W:0]   quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= coef_i * smp_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign rnd = $signed({acc_q[ACC_W-1], acc_q}) + RND_HALF;
  assign quo = rnd[ACC_W:FRAC_W];

  always_comb begin
    if (quo > SAT_MAX) begin
      res_o = 16'sh7fff;
    end else if (quo < SAT_MIN) begin
      res_o = 16'sh8000;
    end else begin
      res_o = quo[SMP_W-1:0];
    end
  end

  assign busy_o = pv_q;

endmodule

[sv/stereo_fir_filter.sv]
// Two-channel direct-form FIR filter with one iterative multiply-accumulate per channel.
//
// Input channel (in_valid_i / in_ready_o): each beat carries a command. A sample
// command feeds one left/right pair and yields one output beat; a coefficient
// write loads one tap of one channel (index past the last tap is dropped) and
// yields nothing; an unused command is dropped.
// Output channel (out_valid_o / out_ready_i): one filtered pair per sample beat.
// A sample walks the taps one per cycle through the coefficient and delay RAMs;
// the block takes no new beat until the sum is done and its result is loaded into
// the output register, and in_ready_o rises again as that result appears.
// A coefficient write leaves in_ready_o high for the next beat.
// After reset the block sweeps the RAMs, loading unity at the middle tap and
// zeroes elsewhere; in_ready_o stays low meanwhile.
// The result sits in an output register: the next beat is accepted while it
// waits, and a finished sum holds until the register is free.
module stereo_fir_filter import sfir_pkg::*; #(
  parameter int unsigned TAPS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic signed [SMP_W-1:0]  left_sample_i,
  input  logic signed [SMP_W-1:0]  right_sample_i,
  input  logic [7:0]               coeff_index_i,
  input  logic signed [COEF_W-1:0] coeff_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SMP_W-1:0]  left_out_o,
  output logic signed [SMP_W-1:0]  right_out_o
);

  localparam int unsigned DLEN  = TAPS - 1;
  localparam int unsigned AW    = $clog2(TAPS);
  localparam int unsigned DAW   = $clog2(DLEN);
  localparam int unsigned IW    = ((AW > 8) ? AW : 8) + 1;
  localparam int unsigned ACC_W = PROD_W + $clog2(TAPS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  state_e                   state_q;
  logic [AW-1:0]            clr_q;
  logic [AW-1:0]            tap_q;
  logic [DAW-1:0]           slot_q;
  logic [DAW-1:0]           ptr_q;
  logic                     iss_q;
  logic                     use_x_q;
  logic                     out_vld_q;
  logic signed [SMP_W-1:0]  left_x_q;
  logic signed [SMP_W-1:0]  right_x_q;
  logic signed [SMP_W-1:0]  left_out_q;
  logic signed [SMP_W-1:0]  right_out_q;

  logic                     clearing;
  logic                     in_acc;
  logic                     is_smp;
  logic [IW-1:0]            idx_ext;
  logic                     idx_ok;
  logic                     lc_we;
  logic                     rc_we;
  logic [AW-1:0]            c_waddr;
  logic signed [COEF_W-1:0] c_wdata;
  logic                     d_we;
  logic [DAW-1:0]           d_waddr;
  logic signed [SMP_W-1:0]  ld_wdata;
  logic signed [SMP_W-1:0]  rd_wdata;
  logic [COEF_W-1:0]        lc_rdata;
  logic [COEF_W-1:0]        rc_rdata;
  logic [SMP_W-1:0]         ld_rdata;
  logic [SMP_W-1:0]         rd_rdata;
  logic signed [SMP_W-1:0]  l_smp;
  logic signed [SMP_W-1:0]  r_smp;
  mac_ctrl_t                mac_ctrl;
  logic                     l_busy;
  logic                     r_busy;
  logic signed [SMP_W-1:0]  l_res;
  logic signed [SMP_W-1:0]  r_res;
  logic                     flush_done;
  logic                     load;

  assign clearing   = (state_q == ST_CLEAR);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_smp     = (cmd_i == CMD_SAMPLE);
  assign idx_ext    = IW'(coeff_index_i);
  assign idx_ok     = (idx_ext < IW'(TAPS));

  assign lc_we   = clearing || (in_acc && cmd_i == CMD_WR_LEFT && idx_ok);
  assign rc_we   = clearing || (in_acc && cmd_i == CMD_WR_RIGHT && idx_ok);
  assign c_waddr = clearing ? clr_q : idx_ext[AW-1:0];
  assign c_wdata = clearing ? ((clr_q == AW'(TAPS / 2)) ? COEF_UNITY : '0) : coeff_value_i;

  assign flush_done = (state_q == ST_FLUSH) && !iss_q && !l_busy && !r_busy;
  assign load       = flush_done && (!out_vld_q || out_ready_i);

  assign d_we     = (clearing && clr_q < AW'(DLEN)) || load;
  assign d_waddr  = clearing ? clr_q[DAW-1:0] : ptr_q;
  assign ld_wdata = clearing ? '0 : left_x_q;
  assign rd_wdata = clearing ? '0 : right_x_q;

  sfir_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_lcoef (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (tap_q),
    .rdata_o (lc_rdata)
  );

  sfir_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_rcoef (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (tap_q),
    .rdata_o (rc_rdata)
  );

  sfir_ram #(.WIDTH(SMP_W), .DEPTH(DLEN)) u_ldly (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (slot_q),
    .rdata_o (ld_rdata)
  );

  sfir_ram #(.WIDTH(SMP_W), .DEPTH(DLEN)) u_rdly (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (rd_wdata),
    .raddr_i (slot_q),
    .rdata_o (rd_rdata)
  );

  assign mac_ctrl.clr = in_acc && is_smp;
  assign mac_ctrl.en  = iss_q;
  assign l_smp = use_x_q ? left_x_q : $signed(ld_rdata);
  assign r_smp = use_x_q ? right_x_q : $signed(rd_rdata);

  sfir_mac #(.ACC_W(ACC_W)) u_lmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i ($signed(lc_rdata)),
    .smp_i  (l_smp),
    .busy_o (l_busy),
    .res_o  (l_res)
  );

  sfir_mac #(.ACC_W(ACC_W)) u_rmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i ($signed(rc_rdata)),
    .smp_i  (r_smp),
    .busy_o (r_busy),
    .res_o  (r_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      tap_q     <= '0;
      slot_q    <= '0;
      ptr_q     <= '0;
      iss_q     <= 1'b0;
      use_x_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      iss_q   <= (state_q == ST_RUN);
      use_x_q <= (state_q == ST_RUN) && (tap_q == AW'(TAPS - 1));
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(TAPS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && is_smp) begin
            tap_q   <= '0;
            slot_q  <= ptr_q;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          tap_q  <= tap_q + 1'b1;
          slot_q <= (slot_q == DAW'(DLEN - 1)) ? '0 : slot_q + 1'b1;
          if (tap_q == AW'(TAPS - 1)) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (load) begin
            ptr_q   <= (ptr_q == DAW'(DLEN - 1)) ? '0 : ptr_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_smp) begin
      left_x_q  <= left_sample_i;
      right_x_q <= right_sample_i;
    end
    if (load) begin
      left_out_q  <= l_res;
      right_out_q <= r_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule
